FILE: sv/i2cftq_pkg.sv
// shared types, constants and helpers for the framed i2c transmit queue
// no dependencies; every other file of the block uses this package
package i2cftq_pkg;

    localparam int DEPTH = 256;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int FP_W  = 9;

    // request actions
    localparam logic [1:0] ACT_PUSH = 2'd0;
    localparam logic [1:0] ACT_IRQ  = 2'd1;
    localparam logic [1:0] ACT_POLL = 2'd2;

    // bus commands
    localparam logic [1:0] CMD_NONE  = 2'd0;
    localparam logic [1:0] CMD_START = 2'd1;
    localparam logic [1:0] CMD_WRITE = 2'd2;
    localparam logic [1:0] CMD_STOP  = 2'd3;

    typedef logic [PTR_W-1:0] ptr_t;
    typedef logic [CNT_W-1:0] cnt_t;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] data_byte;
        logic       bus_collision;
        logic       bus_stop_seen;
        logic       bus_start_active;
    } req_t;

    typedef struct packed {
        logic [1:0]      bus_command;
        logic [7:0]      tx_byte;
        logic            collision_seen;
        logic [FP_W-1:0] frames_pending;
        logic            queue_full;
    } rsp_t;

    function automatic ptr_t next_ptr(input ptr_t p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : ptr_t'(p + 1'b1);
    endfunction

endpackage

FILE: sv/i2cftq_ifs.sv
// valid/ready channel interfaces: request, result and configuration write
// depends on i2cftq_pkg for the payload types
interface i2cftq_req_if;
    logic               valid;
    logic               ready;
    i2cftq_pkg::req_t   payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface i2cftq_rsp_if;
    logic               valid;
    logic               ready;
    i2cftq_pkg::rsp_t   payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface i2cftq_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: sv/i2cftq_ram.sv
// byte queue storage: one write port, one read port with registered data
// depends on i2cftq_pkg for depth and pointer width
module i2cftq_ram (
    input  logic              clk,
    input  logic              wr_en,
    input  i2cftq_pkg::ptr_t  wr_addr,
    input  logic [7:0]        wr_data,
    input  logic              rd_en,
    input  i2cftq_pkg::ptr_t  rd_addr,
    output logic [7:0]        rd_data
);
    import i2cftq_pkg::*;

    logic [7:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: sv/i2c_framed_tx_queue_retry_unit.sv
// framed transmit queue with collision rollback for a multi-master i2c link
// depends on i2cftq_pkg, i2cftq_ifs and i2cftq_ram
//
//   channel  | dir | payload                                          | accepted when
//   req      | in  | action, data_byte, bus_collision, stop, start    | valid & ready
//   rsp      | out | bus_command, tx_byte, collision_seen, frames,... | valid & ready
//   cfg      | in  | data (device_id)                                 | valid & ready
//
// push, poll and interrupts without a queue byte load the rsp register directly;
// an interrupt that sends a frame byte waits in S_READ for the registered ram read.
// reset clears pointers, counters and flags at once; the ram is not cleared.
// a result waits in the rsp register; a new request is taken in the same
// cycle that the waiting result is taken. cfg is always ready.
module i2c_framed_tx_queue_retry_unit (
    input  logic          clk,
    input  logic          rst_n,
    i2cftq_req_if.sink    req,
    i2cftq_rsp_if.source  rsp,
    i2cftq_cfg_if.sink    cfg
);
    import i2cftq_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_READ = 2'b10
    } state_t;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'b001,
        PH_SENDING = 3'b010,
        PH_END     = 3'b100
    } phase_t;

    state_t     state_reg, state_next;
    phase_t     phase_reg, phase_next;
    ptr_t       wp_reg, wp_next;
    ptr_t       rp_reg, rp_next;
    ptr_t       fsp_reg, fsp_next;
    cnt_t       bc_reg, bc_next;
    cnt_t       sent_reg, sent_next;
    cnt_t       fc_reg, fc_next;
    logic [1:0] hi_reg, hi_next;
    logic       sp_reg, sp_next;
    logic       coll_reg, coll_next;
    logic [7:0] dev_reg;
    logic       rsp_valid_reg, rsp_valid_next;
    rsp_t       rsp_reg, rsp_next;

    logic       req_fire;
    logic       out_free;
    logic       mem_wr_en;
    logic       mem_rd_en;
    logic [7:0] mem_rd_data;
    logic [1:0] cmd;
    logic [7:0] txb;
    logic       full;
    logic       load;

    // outcome of committing the sent frame
    logic       cm_all;
    ptr_t       cm_fsp;
    cnt_t       cm_bc;
    cnt_t       cm_fc;

    assign out_free  = !rsp_valid_reg || rsp.ready;
    assign req.ready = (state_reg == S_IDLE) && out_free;
    assign req_fire  = req.valid && req.ready;
    assign cfg.ready = 1'b1;
    assign rsp.valid   = rsp_valid_reg;
    assign rsp.payload = rsp_reg;

    // write and read never fall in the same cycle, so no forwarding is needed
    i2cftq_ram u_ram (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (wp_reg),
        .wr_data (req.payload.data_byte),
        .rd_en   (mem_rd_en),
        .rd_addr (rp_reg),
        .rd_data (mem_rd_data)
    );

    always_comb
    begin
        cm_all = (sent_reg >= bc_reg);
        cm_fsp = cm_all ? wp_reg : rp_reg;
        cm_bc  = cm_all ? '0 : cnt_t'(bc_reg - sent_reg);
        cm_fc  = (cm_all || fc_reg == '0) ? '0 : cnt_t'(fc_reg - 1'b1);
    end

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        wp_next    = wp_reg;
        rp_next    = rp_reg;
        fsp_next   = fsp_reg;
        bc_next    = bc_reg;
        sent_next  = sent_reg;
        fc_next    = fc_reg;
        hi_next    = hi_reg;
        sp_next    = sp_reg;
        coll_next  = coll_reg;
        mem_wr_en  = 1'b0;
        mem_rd_en  = 1'b0;
        cmd        = CMD_NONE;
        txb        = 8'd0;
        full       = 1'b0;
        load       = 1'b0;
        rsp_next   = rsp_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    case (req.payload.action)
                        ACT_PUSH:
                        begin
                            if (bc_reg >= cnt_t'(DEPTH))
                            begin
                                full = 1'b1;
                            end
                            else
                            begin
                                mem_wr_en = 1'b1;
                                if (req.payload.data_byte == 8'd0)
                                begin
                                    fc_next = cnt_t'(fc_reg + 1'b1);
                                end
                                wp_next = next_ptr(wp_reg);
                                bc_next = cnt_t'(bc_reg + 1'b1);
                            end
                        end
                        ACT_IRQ:
                        begin
                            if (req.payload.bus_collision)
                            begin
                                // roll back to the frame start for a resend
                                phase_next = PH_IDLE;
                                coll_next  = 1'b1;
                                rp_next    = fsp_reg;
                                sent_next  = '0;
                            end
                            else if (req.payload.bus_stop_seen)
                            begin
                                phase_next = PH_IDLE;
                            end
                            else if (req.payload.bus_start_active)
                            begin
                                if (phase_reg == PH_SENDING)
                                begin
                                    cmd = CMD_WRITE;
                                    case (hi_reg)
                                        2'd0:
                                        begin
                                            txb     = 8'd0;
                                            hi_next = 2'd1;
                                        end
                                        2'd1:
                                        begin
                                            txb     = dev_reg;
                                            hi_next = 2'd2;
                                        end
                                        default:
                                        begin
                                            // frame byte: result follows the ram read
                                            mem_rd_en  = 1'b1;
                                            rp_next    = next_ptr(rp_reg);
                                            if (sent_reg < cnt_t'(DEPTH))
                                            begin
                                                sent_next = cnt_t'(sent_reg + 1'b1);
                                            end
                                            state_next = S_READ;
                                        end
                                    endcase
                                end
                                else if (phase_reg == PH_END)
                                begin
                                    phase_next = PH_IDLE;
                                    sp_next    = 1'b1;
                                    cmd        = CMD_STOP;
                                end
                            end
                        end
                        ACT_POLL:
                        begin
                            if (sp_reg && req.payload.bus_stop_seen)
                            begin
                                sp_next  = 1'b0;
                                rp_next  = cm_all ? wp_reg : rp_reg;
                                fsp_next = cm_fsp;
                                bc_next  = cm_bc;
                                fc_next  = cm_fc;
                                sent_next = '0;
                                if (cm_fc != '0 && !req.payload.bus_start_active)
                                begin
                                    hi_next    = 2'd0;
                                    phase_next = PH_SENDING;
                                    coll_next  = 1'b0;
                                    cmd        = CMD_START;
                                end
                            end
                            else if (fc_reg != '0 && !req.payload.bus_start_active)
                            begin
                                if (sp_reg)
                                begin
                                    sp_next  = 1'b0;
                                    rp_next  = cm_all ? wp_reg : rp_reg;
                                    fsp_next = cm_fsp;
                                    bc_next  = cm_bc;
                                    fc_next  = cm_fc;
                                    sent_next = '0;
                                end
                                else
                                begin
                                    hi_next    = 2'd0;
                                    phase_next = PH_SENDING;
                                    coll_next  = 1'b0;
                                    cmd        = CMD_START;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase

                    if (!mem_rd_en)
                    begin
                        load                    = 1'b1;
                        rsp_next.bus_command    = cmd;
                        rsp_next.tx_byte        = txb;
                        rsp_next.collision_seen = coll_next;
                        rsp_next.frames_pending = FP_W'(fc_next);
                        rsp_next.queue_full     = full;
                    end
                end
            end
            S_READ:
            begin
                if (out_free)
                begin
                    load                    = 1'b1;
                    rsp_next.bus_command    = CMD_WRITE;
                    rsp_next.tx_byte        = mem_rd_data;
                    rsp_next.collision_seen = coll_reg;
                    rsp_next.frames_pending = FP_W'(fc_reg);
                    rsp_next.queue_full     = 1'b0;
                    if (mem_rd_data == 8'd0)
                    begin
                        phase_next = PH_END;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        rsp_valid_next = load ? 1'b1 : (rsp.ready ? 1'b0 : rsp_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= PH_IDLE;
            wp_reg        <= '0;
            rp_reg        <= '0;
            fsp_reg       <= '0;
            bc_reg        <= '0;
            sent_reg      <= '0;
            fc_reg        <= '0;
            hi_reg        <= 2'd0;
            sp_reg        <= 1'b0;
            coll_reg      <= 1'b0;
            dev_reg       <= 8'd0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            wp_reg        <= wp_next;
            rp_reg        <= rp_next;
            fsp_reg       <= fsp_next;
            bc_reg        <= bc_next;
            sent_reg      <= sent_next;
            fc_reg        <= fc_next;
            hi_reg        <= hi_next;
            sp_reg        <= sp_next;
            coll_reg      <= coll_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg.valid && cfg.ready)
            begin
                dev_reg <= cfg.data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

endmodule

FILE: sv/i2cftq_checker.sv
// port-level checks of the framed i2c transmit queue, bound to the top level
// depends on i2cftq_pkg and i2c_framed_tx_queue_retry_unit
module i2cftq_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              req_valid,
    input logic              req_ready,
    input logic              rsp_valid,
    input logic              rsp_ready,
    input i2cftq_pkg::rsp_t  rsp_payload
);
    import i2cftq_pkg::*;

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
        else $error("result dropped or changed while stalled");

    // a request is only taken when the result register can take its result
    a_req_room: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |-> !rsp_valid || rsp_ready)
        else $error("request accepted while result register blocked");

    a_txb_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_payload.bus_command != CMD_WRITE |-> rsp_payload.tx_byte == 8'd0)
        else $error("tx byte set without a write command");

    a_full_none: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_payload.queue_full |-> rsp_payload.bus_command == CMD_NONE)
        else $error("dropped push carries a bus command");

    a_start_clr: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_payload.bus_command == CMD_START |-> !rsp_payload.collision_seen)
        else $error("collision flag not cleared on start");

endmodule

bind i2c_framed_tx_queue_retry_unit i2cftq_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .rsp_payload (rsp.payload)
);

FILE: bench/i2c_framed_tx_queue_retry_unit_test.sv
// testbench for the framed i2c transmit queue: directed frames, then random frame traffic
// with collisions, mid-frame stops, full-queue drops and random idling on both channels
// depends on i2cftq_pkg, the i2cftq channel interfaces and the top level of the block
`timescale 1ns / 1ps

module i2c_framed_tx_queue_retry_unit_test;
    import i2cftq_pkg::*;

    localparam int         CLK_PERIOD  = 10;
    localparam int         QUIET_LIMIT = 2000;
    localparam int         PHASE_ITEMS = 375;
    localparam logic [1:0] ACT_UNUSED  = 2'd3;

    typedef enum logic [2:0] {
        TX_IDLE    = 3'b001,
        TX_SENDING = 3'b010,
        TX_END     = 3'b100
    } tx_state_t;

    logic clk = 1'b0;
    logic rst_n;

    i2cftq_req_if req_if ();
    i2cftq_rsp_if rsp_if ();
    i2cftq_cfg_if cfg_if ();

    i2c_framed_tx_queue_retry_unit u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if),
        .cfg   (cfg_if)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // shadow of the transmit queue
    logic [7:0]      tq_mem [DEPTH];
    bit              tq_written [DEPTH];
    ptr_t            wr_ptr;
    ptr_t            rd_ptr;
    ptr_t            frame_head;
    cnt_t            bytes_held;
    cnt_t            sent_bytes;
    logic [FP_W-1:0] frames_queued;
    tx_state_t       tx_state;
    logic [1:0]      hdr_idx;
    logic            stop_wait;
    logic            collided;
    logic [7:0]      dev_id;

    req_t pending_requests [$];
    rsp_t expected_results [$];

    int errors;
    int results_checked;
    int n_requests;
    int n_starts;
    int n_writes;
    int n_stops;
    int n_drops;
    int n_collisions;
    int req_gap;
    int req_calm;
    int rsp_stall;
    int rsp_calm;
    int quiet_cycles;
    bit fill_mode;
    int overflow_left;

    function automatic ptr_t advance(ptr_t p);
        return ptr_t'((int'(p) + 1) % DEPTH);
    endfunction

    function automatic void clear_queue_state();
        foreach (tq_written[i])
            tq_written[i] = 1'b0;
        wr_ptr        = '0;
        rd_ptr        = '0;
        frame_head    = '0;
        bytes_held    = '0;
        sent_bytes    = '0;
        frames_queued = '0;
        tx_state      = TX_IDLE;
        hdr_idx       = '0;
        stop_wait     = 1'b0;
        collided      = 1'b0;
        dev_id        = '0;
    endfunction

    // frees the sent bytes; empties the queue when they cover everything held
    function automatic void commit_sent_frame();
        if (sent_bytes >= bytes_held)
        begin
            rd_ptr        = wr_ptr;
            frame_head    = wr_ptr;
            bytes_held    = '0;
            frames_queued = '0;
        end
        else
        begin
            bytes_held = bytes_held - sent_bytes;
            frame_head = rd_ptr;
            if (frames_queued > 0)
                frames_queued = frames_queued - 1'b1;
        end
        sent_bytes = '0;
    endfunction

    function automatic rsp_t bus_response(req_t r);
        rsp_t o;
        o = '0;
        o.bus_command = CMD_NONE;
        case (r.action)
            ACT_PUSH:
            begin
                if (bytes_held >= DEPTH)
                    o.queue_full = 1'b1;
                else
                begin
                    tq_mem[wr_ptr]     = r.data_byte;
                    tq_written[wr_ptr] = 1'b1;
                    if (r.data_byte == 8'd0)
                        frames_queued = frames_queued + 1'b1;
                    wr_ptr     = advance(wr_ptr);
                    bytes_held = bytes_held + 1'b1;
                end
            end
            ACT_IRQ:
            begin
                if (r.bus_collision)
                begin
                    tx_state   = TX_IDLE;
                    collided   = 1'b1;
                    rd_ptr     = frame_head;
                    sent_bytes = '0;
                end
                else if (r.bus_stop_seen)
                    tx_state = TX_IDLE;
                else if (r.bus_start_active)
                begin
                    if (tx_state == TX_SENDING)
                    begin
                        o.bus_command = CMD_WRITE;
                        if (hdr_idx == 2'd0)
                            hdr_idx = 2'd1;
                        else if (hdr_idx == 2'd1)
                        begin
                            o.tx_byte = dev_id;
                            hdr_idx   = 2'd2;
                        end
                        else
                        begin
                            o.tx_byte = tq_mem[rd_ptr];
                            rd_ptr    = advance(rd_ptr);
                            if (sent_bytes < DEPTH)
                                sent_bytes = sent_bytes + 1'b1;
                            if (o.tx_byte == 8'd0)
                                tx_state = TX_END;
                        end
                    end
                    else if (tx_state == TX_END)
                    begin
                        tx_state      = TX_IDLE;
                        stop_wait     = 1'b1;
                        o.bus_command = CMD_STOP;
                    end
                end
            end
            ACT_POLL:
            begin
                if (stop_wait && r.bus_stop_seen)
                begin
                    stop_wait = 1'b0;
                    commit_sent_frame();
                end
                if (frames_queued > 0 && !r.bus_start_active)
                begin
                    if (stop_wait)
                    begin
                        stop_wait = 1'b0;
                        commit_sent_frame();
                    end
                    else
                    begin
                        hdr_idx       = 2'd0;
                        tx_state      = TX_SENDING;
                        collided      = 1'b0;
                        o.bus_command = CMD_START;
                    end
                end
            end
            default:
            begin
            end
        endcase
        o.collision_seen = collided;
        o.frames_pending = frames_queued;
        return o;
    endfunction

    function automatic req_t mk(logic [1:0] a, logic [7:0] d, logic c, logic s, logic st);
        req_t r;
        r.action           = a;
        r.data_byte        = d;
        r.bus_collision    = c;
        r.bus_stop_seen    = s;
        r.bus_start_active = st;
        return r;
    endfunction

    function automatic req_t random_request();
        return mk(2'($urandom_range(0, 3)), 8'($urandom), 1'($urandom), 1'($urandom),
                  1'($urandom));
    endfunction

    // mostly well-formed frame traffic; disturbances are rarer while over 64 bytes are held
    function automatic req_t pick_request();
        bit disturb;
        if (fill_mode)
        begin
            if (bytes_held < DEPTH - 1)
                return mk(ACT_PUSH, 8'($urandom_range(1, 255)), 1'b0, 1'b0, 1'b0);
            if (bytes_held == DEPTH - 1)
                return mk(ACT_PUSH, 8'd0, 1'b0, 1'b0, 1'b0);
            overflow_left--;
            if (overflow_left <= 0)
                fill_mode = 1'b0;
            return mk(ACT_PUSH, 8'($urandom), 1'b0, 1'b0, 1'b0);
        end
        disturb = (bytes_held > 64) ? ($urandom_range(0, 399) == 0)
                                    : ($urandom_range(0, 24) == 0);
        if (disturb)
        begin
            case ($urandom_range(0, 2))
                0:       return mk(ACT_IRQ, 8'($urandom), 1'b1, 1'($urandom), 1'($urandom));
                1:       return mk(ACT_IRQ, 8'($urandom), 1'b0, 1'b1, 1'($urandom));
                default: return random_request();
            endcase
        end
        if (tx_state == TX_SENDING && $urandom_range(0, 19) == 0)
            return mk(ACT_PUSH, 8'($urandom), 1'b0, 1'b0, 1'b0);
        if (tx_state != TX_IDLE)
            return mk(ACT_IRQ, 8'($urandom), 1'b0, 1'b0, 1'b1);
        if (stop_wait)
            return mk(ACT_POLL, 8'($urandom), 1'b0, 1'($urandom),
                      1'($urandom_range(0, 5) == 0));
        if (frames_queued > 0 && $urandom_range(0, 2) != 0)
            return mk(ACT_POLL, 8'($urandom), 1'b0, 1'($urandom),
                      1'($urandom_range(0, 7) == 0));
        if ($urandom_range(0, 299) == 0)
        begin
            fill_mode     = 1'b1;
            overflow_left = 3;
        end
        if ($urandom_range(0, 5) == 0)
            return mk(ACT_PUSH, 8'd0, 1'b0, 1'b0, 1'b0);
        return mk(ACT_PUSH, 8'($urandom_range(1, 255)), 1'b0, 1'b0, 1'b0);
    endfunction

    task automatic queue_request(req_t r);
        rsp_t want;
        // never let the block read a queue entry that was never written
        if (r.action == ACT_IRQ && !r.bus_collision && !r.bus_stop_seen && r.bus_start_active
            && tx_state == TX_SENDING && hdr_idx >= 2'd2 && !tq_written[rd_ptr])
            r.bus_collision = 1'b1;
        // a full queue without a frame end could never drain
        if (r.action == ACT_PUSH && bytes_held == DEPTH - 1 && frames_queued == 0)
            r.data_byte = 8'd0;
        if (r.action == ACT_IRQ && r.bus_collision)
            n_collisions++;
        want = bus_response(r);
        case (want.bus_command)
            CMD_START: n_starts++;
            CMD_WRITE: n_writes++;
            CMD_STOP:  n_stops++;
            default:   ;
        endcase
        if (want.queue_full)
            n_drops++;
        n_requests++;
        pending_requests.push_back(r);
        expected_results.push_back(want);
    endtask

    task automatic write_device_id(logic [7:0] value);
        @(posedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= value;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        dev_id = value;
    endtask

    task automatic settle();
        while (pending_requests.size() != 0 || expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic report_mismatch(string what);
        $display("mismatch at %0t: %s", $realtime, what);
        errors++;
    endtask

    task automatic check_field(string name, logic [8:0] got, logic [8:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s got %0d expected %0d",
                                      results_checked, name, got, want));
    endtask

    function automatic int draw_wait(inout int calm);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
        begin
            calm = $urandom_range(20, 60);
            return 0;
        end
        return $urandom_range(0, 17);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : request_driver
        if (!rst_n)
        begin
            req_if.valid   <= 1'b0;
            req_if.payload <= '0;
            req_gap        <= 0;
        end
        else if (!req_if.valid || req_if.ready)
        begin
            if (req_gap != 0)
            begin
                req_if.valid <= 1'b0;
                req_gap      <= req_gap - 1;
            end
            else if (pending_requests.size() != 0)
            begin
                req_if.valid   <= 1'b1;
                req_if.payload <= pending_requests.pop_front();
                req_gap        <= draw_wait(req_calm);
            end
            else
                req_if.valid <= 1'b0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        int   stall;
        rsp_t want;
        rsp_t got;
        if (!rst_n)
        begin
            rsp_if.ready <= 1'b0;
            rsp_stall    <= 0;
        end
        else
        begin
            stall = rsp_stall;
            if (rsp_if.valid && rsp_if.ready)
            begin
                got = rsp_if.payload;
                if (expected_results.size() == 0)
                    report_mismatch("result arrived with nothing expected");
                else
                begin
                    want = expected_results.pop_front();
                    check_field("bus_command", 9'(got.bus_command), 9'(want.bus_command));
                    check_field("tx_byte", 9'(got.tx_byte), 9'(want.tx_byte));
                    check_field("collision_seen", 9'(got.collision_seen),
                                9'(want.collision_seen));
                    check_field("frames_pending", got.frames_pending, want.frames_pending);
                    check_field("queue_full", 9'(got.queue_full), 9'(want.queue_full));
                end
                results_checked++;
                stall = draw_wait(rsp_calm);
            end
            if (stall != 0)
            begin
                rsp_if.ready <= 1'b0;
                rsp_stall    <= stall - 1;
            end
            else
            begin
                rsp_if.ready <= 1'b1;
                rsp_stall    <= 0;
            end
        end
    end

    // ends the run when nothing moves on any channel for too long
    always @(posedge clk)
    begin : watchdog
        if (rst_n !== 1'b1 || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)
            || (cfg_if.valid && cfg_if.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("watchdog: no request or result moved for %0d cycles", QUIET_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin : stimulus
        logic [7:0] ids [4];
        rst_n        <= 1'b0;
        cfg_if.valid <= 1'b0;
        cfg_if.data  <= '0;
        clear_queue_state();
        ids = '{8'h00, 8'hA5, 8'h5A, 8'h00};
        ids[3] = 8'($urandom_range(1, 254));
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_device_id(8'hFF);
        // nothing to do yet: unused action, bare interrupt, poll of an empty queue
        queue_request(mk(ACT_UNUSED, 8'hFF, 1'b1, 1'b1, 1'b1));
        queue_request(mk(ACT_IRQ, 8'h00, 1'b0, 1'b0, 1'b0));
        queue_request(mk(ACT_POLL, 8'h00, 1'b0, 1'b0, 1'b0));
        queue_request(mk(ACT_PUSH, 8'hFF, 1'b0, 1'b0, 1'b0));
        queue_request(mk(ACT_PUSH, 8'h80, 1'b0, 1'b0, 1'b0));
        queue_request(mk(ACT_PUSH, 8'h01, 1'b0, 1'b0, 1'b0));
        queue_request(mk(ACT_PUSH, 8'h00, 1'b0, 1'b0, 1'b0));
        // bus held by another master, then a start
        queue_request(mk(ACT_POLL, 8'h00, 1'b0, 1'b0, 1'b1));
        queue_request(mk(ACT_POLL, 8'h00, 1'b0, 1'b1, 1'b0));
        repeat (3) queue_request(mk(ACT_IRQ, 8'h00, 1'b0, 1'b0, 1'b1));
        // collision wins over stop and start: roll back to the frame start
        queue_request(mk(ACT_IRQ, 8'h00, 1'b1, 1'b1, 1'b1));
        queue_request(mk(ACT_POLL, 8'h00, 1'b0, 1'b0, 1'b0));
        repeat (3) queue_request(mk(ACT_IRQ, 8'h00, 1'b0, 1'b0, 1'b1));
        // stop in mid frame keeps the read position
        queue_request(mk(ACT_IRQ, 8'h00, 1'b0, 1'b1, 1'b1));
        queue_request(mk(ACT_POLL, 8'h00, 1'b0, 1'b0, 1'b0));
        repeat (6) queue_request(mk(ACT_IRQ, 8'h00, 1'b0, 1'b0, 1'b1));
        queue_request(mk(ACT_POLL, 8'h00, 1'b0, 1'b1, 1'b0));
        settle();

        for (int p = 0; p < 4; p++)
        begin
            write_device_id(ids[p]);
            if (p == 1)
            begin
                fill_mode     = 1'b1;
                overflow_left = 3;
            end
            repeat (PHASE_ITEMS) queue_request(pick_request());
            settle();
        end

        repeat (8) @(posedge clk);
        $display("ran %0d requests: %0d starts, %0d byte writes, %0d stops", n_requests,
                 n_starts, n_writes, n_stops);
        $display("%0d collisions, %0d dropped pushes, %0d results checked", n_collisions,
                 n_drops, results_checked);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
